// ===== hw/rtl/slfp_pkg.sv =====
// Shared types, constants and address decode for the serial flash programming port.
`default_nettype none
package slfp_pkg;

   // Default program store depth in 16-bit words
   localparam int unsigned PROGRAM_WORDS_DEFAULT = 16384;

   // Item kinds sorted out by the front end
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_PTR    = 2'd1;
   localparam logic [1:0] KIND_LATCH  = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   // Programming commands (low four bits of the shift word)
   localparam logic [3:0] CMD_CORE    = 4'h0;
   localparam logic [3:0] CMD_LATCH   = 4'h2;
   localparam logic [3:0] CMD_RD      = 4'h8;
   localparam logic [3:0] CMD_RD_INC  = 4'h9;
   localparam logic [3:0] CMD_RD_DEC  = 4'hA;
   localparam logic [3:0] CMD_INC_RD  = 4'hB;
   localparam logic [3:0] CMD_WR      = 4'hC;
   localparam logic [3:0] CMD_WR_INC2 = 4'hD;
   localparam logic [3:0] CMD_WR_DEC2 = 4'hE;
   localparam logic [3:0] CMD_WR_HOLD = 4'hF;

   // Address map
   localparam logic [21:0] ID_LO      = 22'h200000;
   localparam logic [21:0] ID_HI      = 22'h200007;
   localparam logic [21:0] CFG_LO     = 22'h300000;
   localparam logic [21:0] CFG_HI     = 22'h30000D;
   localparam logic [21:0] DBG_LO     = 22'h200028;
   localparam logic [21:0] DBG_HI     = 22'h200037;
   localparam logic [21:0] ERASE_ADDR = 22'h3C0004;
   localparam logic [15:0] ERASE_A    = 16'h0080;
   localparam logic [15:0] ERASE_B    = 16'h0081;
   localparam logic [15:0] ERASE_C    = 16'h0083;
   localparam logic [15:0] ERASE_LO   = 16'h0088;
   localparam logic [15:0] ERASE_HI   = 16'h008B;

   // Configuration register indexes
   localparam logic REG_DEVICE_ID = 1'b0;

   typedef struct packed {
      logic [1:0]  kind;
      logic        clock_pin;
      logic        data_pin;
      logic [21:0] load_value;
   } entry_type;

   typedef struct packed {
      logic       is_id;
      logic       is_cfg;
      logic       is_dev;
      logic       is_dbg;
      logic [2:0] idx;
   } region_type;

   // Decode of the small stores; the program store is checked by the caller first
   function automatic region_type find_region(input logic [21:0] ptr);
      region_type r;
      logic [5:0] dofs;
      r = '0;
      dofs = ptr[5:0] - 6'd40;
      if (ptr >= ID_LO && ptr <= ID_HI) begin
         r.is_id = 1'b1;
         r.idx   = {1'b0, ptr[2:1]};
      end else if (ptr >= CFG_LO && ptr <= CFG_HI) begin
         r.is_cfg = 1'b1;
         r.idx    = ptr[3:1];
      end else if (ptr[21:1] == 21'h1FFFFF) begin
         r.is_dev = 1'b1;
      end else if (ptr >= DBG_LO && ptr <= DBG_HI) begin
         r.is_dbg = 1'b1;
         r.idx    = dofs[3:1];
      end
      return r;
   endfunction

   function automatic logic erase_code(input logic [15:0] p);
      return (p == ERASE_A) || (p == ERASE_B) || (p == ERASE_C) ||
             (p >= ERASE_LO && p <= ERASE_HI);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/slfp_front.sv =====
// Front end: takes items, sorts them by kind and queues them for the back end.
`default_nettype none
module slfp_front
   import slfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic [1:0]  action,
   input  wire logic        clock_pin,
   input  wire logic        data_pin,
   input  wire logic [21:0] load_value,
   output logic             full,
   output logic             not_empty,
   input  wire logic        pop,
   output entry_type        head
);

   entry_type  q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   entry_type  cls;

   // Classify the action
   always_comb begin
      cls.clock_pin  = clock_pin;
      cls.data_pin   = data_pin;
      cls.load_value = load_value;
      case (action)
         2'd0:    cls.kind = KIND_SAMPLE;
         2'd1:    cls.kind = KIND_PTR;
         2'd2:    cls.kind = KIND_LATCH;
         default: cls.kind = KIND_NOP;
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = q_ff[rd_ff];

   // Queue pointers
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/slfp_back.sv =====
// Back end: bit sequencer, table access, program memory and erase sweep.
`default_nettype none
module slfp_back
   import slfp_pkg::*;
#(
   parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        avail,
   input  wire entry_type   head,
   output logic             pop,
   output logic             sweeping,
   input  wire logic [15:0] device_id,
   output logic             rsp_valid,
   output logic             rsp_data_out,
   output logic             rsp_data_drive,
   output logic             rsp_instr_valid,
   output logic [15:0]      rsp_instr_word,
   output logic [21:0]      rsp_pointer_now,
   output logic [7:0]       rsp_latch_now
);

   localparam int unsigned AW = $clog2(PROGRAM_WORDS);
   localparam logic [20:0] PW = 21'(PROGRAM_WORDS);
   localparam logic [AW-1:0] LAST_WORD = AW'(PROGRAM_WORDS - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic           state_ff, state_in;
   logic [19:0]    sw_ff, sw_in;
   logic [4:0]     bc_ff, bc_in;
   logic           rom_ff, rom_in, taken_ff, taken_in;
   logic           last_ff, last_in, drive_ff, drive_in, fall_ff, fall_in;
   logic [21:0]    ptr_ff, ptr_in, rdptr_ff, rdptr_in;
   logic [7:0]     latch_ff, latch_in;
   logic [15:0]    id_ff [4];
   logic [15:0]    cfg_ff [7];
   logic [15:0]    dbg_ff [8];
   logic           sweep_ff, sweep_in;
   logic [AW-1:0]  scnt_ff, scnt_in;

   logic [15:0]    mem [PROGRAM_WORDS];
   logic [15:0]    rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata;

   logic           id_we, cfg_we, dbg_we, erase;
   logic [2:0]     st_idx;
   logic [15:0]    st_data;

   logic           emit, fall, ivalid;
   logic [15:0]    iword, payload, word;
   logic [19:0]    sw1, shifted;
   logic [4:0]     bc1;
   logic [3:0]     cmd;
   logic [7:0]     rbyte;
   region_type     wreg, rreg;
   logic           wprog, rprog, rmapped;

   assign pop      = avail && (state_ff == ST_IDLE) && !sweep_ff;
   assign sweeping = sweep_ff;

   // Step sequencer
   always_comb begin
      state_in = state_ff;
      sw_in    = sw_ff;
      bc_in    = bc_ff;
      rom_in   = rom_ff;
      taken_in = taken_ff;
      last_in  = last_ff;
      drive_in = drive_ff;
      fall_in  = fall_ff;
      ptr_in   = ptr_ff;
      rdptr_in = rdptr_ff;
      latch_in = latch_ff;
      sweep_in = sweep_ff;
      scnt_in  = scnt_ff;
      mem_we   = 1'b0;
      mem_waddr = scnt_ff;
      mem_wdata = 16'hFFFF;
      mem_raddr = rdptr_ff[AW:1];
      id_we = 1'b0;
      cfg_we = 1'b0;
      dbg_we = 1'b0;
      erase = 1'b0;
      emit = 1'b0;
      ivalid = 1'b0;
      iword = 16'd0;
      fall = 1'b0;
      sw1 = sw_ff;
      bc1 = bc_ff;
      cmd = sw_ff[3:0];
      payload = sw_ff[19:4];
      wreg = find_region(ptr_ff);
      wprog = (ptr_ff[21:1] < PW);
      rreg = find_region(rdptr_ff);
      rprog = (rdptr_ff[21:1] < PW);
      word = 16'd0;
      rmapped = 1'b1;
      rbyte = 8'd0;
      shifted = 20'd0;
      st_idx = wreg.idx;
      st_data = payload;

      if (sweep_ff) begin
         // Erase sweep fills the program store with ones
         mem_we  = 1'b1;
         scnt_in = scnt_ff + 1'b1;
         if (scnt_ff == LAST_WORD) begin
            sweep_in = 1'b0;
            scnt_in  = '0;
         end
      end else if (state_ff == ST_READ) begin
         // Table read data is back: place the byte for read-out
         if (rprog) begin
            word = rdata_ff;
         end else if (rreg.is_id) begin
            word = id_ff[rreg.idx[1:0]];
         end else if (rreg.is_cfg) begin
            word = cfg_ff[rreg.idx];
         end else if (rreg.is_dev) begin
            word = device_id;
         end else if (rreg.is_dbg) begin
            word = dbg_ff[rreg.idx];
         end else begin
            rmapped = 1'b0;
         end
         rbyte = rdptr_ff[0] ? word[15:8] : word[7:0];
         if (rmapped) begin
            sw_in = sw_ff | {1'b0, rbyte, 11'd0};
         end else begin
            latch_in = 8'd0;
         end
         rom_in = 1'b1;
         if (fall_ff && bc_ff >= 5'd1 && bc_ff <= 5'd20) begin
            shifted  = sw_in >> (bc_ff - 5'd1);
            drive_in = shifted[0];
         end
         state_in = ST_IDLE;
         emit = 1'b1;
      end else if (pop) begin
         emit = 1'b1;
         case (head.kind)
            KIND_PTR: begin
               ptr_in = head.load_value;
            end
            KIND_LATCH: begin
               latch_in = head.load_value[7:0];
            end
            KIND_SAMPLE: begin
               fall = last_ff && !head.clock_pin;
               last_in = head.clock_pin;
               if (fall) begin
                  if (!rom_ff && bc_ff < 5'd20) begin
                     sw1 = sw_ff | (20'(head.data_pin) << bc_ff);
                  end
                  bc1 = bc_ff + 5'd1;
               end
               sw_in = sw1;
               bc_in = bc1;
               cmd = sw1[3:0];
               payload = sw1[19:4];
               st_data = payload;
               if (bc1 == 5'd5 && !taken_ff) begin
                  // Command decode after the fifth bit
                  taken_in = 1'b1;
                  case (cmd)
                     CMD_CORE, CMD_WR, CMD_WR_INC2, CMD_WR_DEC2, CMD_WR_HOLD: begin
                     end
                     CMD_LATCH: begin
                        sw_in  = sw1 | {1'b0, latch_ff, 11'd0};
                        rom_in = 1'b1;
                     end
                     CMD_RD, CMD_RD_INC, CMD_RD_DEC, CMD_INC_RD: begin
                        rdptr_in = (cmd == CMD_INC_RD) ? ptr_ff + 22'd1 : ptr_ff;
                        if (cmd == CMD_RD_INC || cmd == CMD_INC_RD) begin
                           ptr_in = ptr_ff + 22'd1;
                        end else if (cmd == CMD_RD_DEC) begin
                           ptr_in = ptr_ff - 22'd1;
                        end
                        mem_raddr = rdptr_in[AW:1];
                        fall_in = fall;
                        state_in = ST_READ;
                        emit = 1'b0;
                     end
                     default: begin
                        sw_in    = 20'd0;
                        bc_in    = 5'd0;
                        taken_in = 1'b0;
                     end
                  endcase
               end else if (bc1 >= 5'd20) begin
                  // Command completion after the twentieth bit
                  case (cmd)
                     CMD_CORE: begin
                        ivalid = 1'b1;
                        iword  = payload;
                     end
                     CMD_WR, CMD_WR_INC2, CMD_WR_DEC2, CMD_WR_HOLD: begin
                        if (wprog) begin
                           mem_we    = 1'b1;
                           mem_waddr = ptr_ff[AW:1];
                           mem_wdata = payload;
                        end else if (wreg.is_id) begin
                           id_we = 1'b1;
                        end else if (wreg.is_cfg) begin
                           cfg_we = 1'b1;
                        end else if (wreg.is_dbg) begin
                           dbg_we = 1'b1;
                        end else if (cmd == CMD_WR && !wreg.is_dev &&
                                     ptr_ff == ERASE_ADDR && erase_code(payload)) begin
                           erase    = 1'b1;
                           sweep_in = 1'b1;
                           scnt_in  = '0;
                        end
                        if (cmd == CMD_WR_INC2) begin
                           ptr_in = ptr_ff + 22'd2;
                        end else if (cmd == CMD_WR_DEC2) begin
                           ptr_in = ptr_ff - 22'd2;
                        end
                     end
                     default: begin
                     end
                  endcase
                  sw_in    = 20'd0;
                  bc_in    = 5'd0;
                  rom_in   = 1'b0;
                  taken_in = 1'b0;
               end
               // Read-out drive on a falling edge
               if (state_in == ST_IDLE && rom_in && fall &&
                   bc_in >= 5'd1 && bc_in <= 5'd20) begin
                  shifted  = sw_in >> (bc_in - 5'd1);
                  drive_in = shifted[0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sw_ff    <= 20'd0;
         bc_ff    <= 5'd0;
         rom_ff   <= 1'b0;
         taken_ff <= 1'b0;
         last_ff  <= 1'b0;
         drive_ff <= 1'b0;
         fall_ff  <= 1'b0;
         ptr_ff   <= 22'd0;
         latch_ff <= 8'd0;
         sweep_ff <= 1'b1;
         scnt_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         sw_ff    <= sw_in;
         bc_ff    <= bc_in;
         rom_ff   <= rom_in;
         taken_ff <= taken_in;
         last_ff  <= last_in;
         drive_ff <= drive_in;
         fall_ff  <= fall_in;
         ptr_ff   <= ptr_in;
         latch_ff <= latch_in;
         sweep_ff <= sweep_in;
         scnt_ff  <= scnt_in;
         rsp_valid <= emit;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rdptr_ff        <= rdptr_in;
      rsp_data_out    <= rom_in & drive_in;
      rsp_data_drive  <= rom_in;
      rsp_instr_valid <= ivalid;
      rsp_instr_word  <= iword;
      rsp_pointer_now <= ptr_in;
      rsp_latch_now   <= latch_in;
   end

   // Small stores, set to ones at reset; a bulk erase sets the ID and configuration stores to ones
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) id_ff[i] <= 16'hFFFF;
         for (int i = 0; i < 7; i++) cfg_ff[i] <= 16'hFFFF;
         for (int i = 0; i < 8; i++) dbg_ff[i] <= 16'hFFFF;
      end else begin
         if (erase) begin
            for (int i = 0; i < 4; i++) id_ff[i] <= 16'hFFFF;
            for (int i = 0; i < 7; i++) cfg_ff[i] <= 16'hFFFF;
         end
         if (id_we) id_ff[st_idx[1:0]] <= st_data;
         if (cfg_we) cfg_ff[st_idx] <= st_data;
         if (dbg_we) dbg_ff[st_idx] <= st_data;
      end
   end

   // Program store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/serial_flash_programming_port.sv =====
// Top level of the serial flash programming port: CSR port, front queue and back end.
//
// Usage: each pin sample or table pointer/latch load is one transfer on the
// req_ channel, taken at a clock edge where start is high and busy is low.
// Every transfer yields one result on the rsp_ ports, flagged by rsp_valid
// for exactly one cycle; the receiver cannot stall it.
// Results are registered: an accepted item is queued, popped by the back end
// sequencer and its result registered; the sample that decodes a table read
// also waits on a program memory read. The back end takes a new item only
// while idle, not during a table read or a sweep; a two-entry queue decouples
// acceptance from execution. A bulk erase sweeps the program store one word
// per cycle over all PROGRAM_WORDS words, holding further items in the queue;
// busy stays high for the whole sweep.
// Reset: clears all control state and runs a pass that fills the program store
// with ones, with busy high, before items are taken.
// Configuration: device_id at byte address 0 over the APB-style port; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none
module serial_flash_programming_port
   import slfp_pkg::*;
#(
   parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_clock_pin,
   input  wire logic        req_data_pin,
   input  wire logic [21:0] req_load_value,
   output logic             rsp_valid,
   output logic             rsp_data_out,
   output logic             rsp_data_drive,
   output logic             rsp_instr_valid,
   output logic [15:0]      rsp_instr_word,
   output logic [21:0]      rsp_pointer_now,
   output logic [7:0]       rsp_latch_now,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic        q_full, q_avail, q_pop, sweeping;
   entry_type   q_head;
   logic [15:0] dev_id_ff;

   assign busy   = q_full | sweeping;
   assign pready = 1'b1;

   // CSR access
   assign prdata = (paddr[2] == REG_DEVICE_ID) ? {16'd0, dev_id_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_id_ff <= 16'd0;
      end else if (psel && penable && pwrite && paddr[2] == REG_DEVICE_ID) begin
         dev_id_ff <= pwdata[15:0];
      end
   end

   slfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (start && !busy),
      .action     (req_action),
      .clock_pin  (req_clock_pin),
      .data_pin   (req_data_pin),
      .load_value (req_load_value),
      .full       (q_full),
      .not_empty  (q_avail),
      .pop        (q_pop),
      .head       (q_head)
   );

   slfp_back #(
      .PROGRAM_WORDS (PROGRAM_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .avail           (q_avail),
      .head            (q_head),
      .pop             (q_pop),
      .sweeping        (sweeping),
      .device_id       (dev_id_ff),
      .rsp_valid       (rsp_valid),
      .rsp_data_out    (rsp_data_out),
      .rsp_data_drive  (rsp_data_drive),
      .rsp_instr_valid (rsp_instr_valid),
      .rsp_instr_word  (rsp_instr_word),
      .rsp_pointer_now (rsp_pointer_now),
      .rsp_latch_now   (rsp_latch_now)
   );

endmodule
`default_nettype wire
